// ===== rtl/cmt_pkg.sv =====
// ----------------------------------------------------------------------------
// cmt_pkg: shared types and constants for the comma token lexer
// Beat payloads, the per-byte result bundle and the lexer mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cmt_pkg;

   localparam int RESULTS_MAX = 3;

   // Character codes the lexer reacts to.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_SLASH = 3'd1,
      MODE_LINE  = 3'd2,
      MODE_BLOCK = 3'd3,
      MODE_STAR  = 3'd4,
      MODE_QUOTE = 3'd5,
      MODE_WORD  = 3'd6
   } mode_type;

   typedef struct packed {
      logic [7:0] text_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] token_byte;
      logic       byte_valid;
      logic       token_end;
      logic       text_end;
      logic       last_of_run;
   } rsp_type;

   // All results caused by one text byte, slot 0 first.
   typedef struct packed {
      rsp_type [RESULTS_MAX-1:0] slot;
      logic [1:0]                count;
   } bundle_type;

endpackage

`default_nettype wire

// ===== rtl/cmt_stream_if.sv =====
// ----------------------------------------------------------------------------
// cmt_stream_if: valid/ready stream channel
// A beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmt_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/cmt_lex_core.sv =====
// ----------------------------------------------------------------------------
// cmt_lex_core: lexer mode and token length state
// Turns one text byte into a bundle of up to three results.
// ----------------------------------------------------------------------------
`default_nettype none

module cmt_lex_core #(
   parameter int MAX_TOKEN_BYTES = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         text_byte,
   input  wire logic               advance,
   output cmt_pkg::bundle_type     bundle
);
   import cmt_pkg::*;

   // Token length counter saturates at MAX_TOKEN_BYTES-1.
   localparam int LEN_W         = $clog2(MAX_TOKEN_BYTES);
   localparam int LEN_LIMIT_VAL = MAX_TOKEN_BYTES - 1;

   mode_type         mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;

   // Saturation point: token length limit minus one.
   logic [LEN_W-1:0] len_limit;
   assign len_limit = LEN_W'(LEN_LIMIT_VAL);

   always_comb begin
      logic       do_word;
      logic       do_add;
      logic [1:0] n;
      rsp_type [RESULTS_MAX-1:0] slots;

      mode_in = mode_ff;
      len_in  = len_ff;
      do_word = 1'b0;
      do_add  = 1'b0;
      n       = 2'd0;
      slots   = '0;

      case (mode_ff)
         MODE_SLASH: begin
            if (text_byte == CHAR_SLASH) begin
               mode_in = MODE_LINE;
            end else if (text_byte == CHAR_STAR) begin
               mode_in = MODE_BLOCK;
            end else begin
               // pending slash opens a word
               slots[0] = '{token_byte: CHAR_SLASH, byte_valid: 1'b1,
                            token_end: 1'b0, text_end: 1'b0, last_of_run: 1'b0};
               n       = 2'd1;
               len_in  = LEN_W'(1);
               do_word = 1'b1;
            end
         end
         MODE_LINE: begin
            if (text_byte == CHAR_NUL) begin
               slots[0].text_end = 1'b1;
               n       = 2'd1;
               mode_in = MODE_IDLE;
            end else if (text_byte == CHAR_LF) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_BLOCK, MODE_STAR: begin
            if (text_byte == CHAR_NUL) begin
               slots[0].text_end = 1'b1;
               n       = 2'd1;
               mode_in = MODE_IDLE;
            end else if (text_byte == CHAR_STAR) begin
               mode_in = MODE_STAR;
            end else if (mode_ff == MODE_STAR && text_byte == CHAR_SLASH) begin
               mode_in = MODE_IDLE;
            end else begin
               mode_in = MODE_BLOCK;
            end
         end
         MODE_QUOTE: begin
            if (text_byte == CHAR_NUL) begin
               slots[0].token_end = 1'b1;
               slots[0].text_end  = 1'b1;
               n       = 2'd1;
               mode_in = MODE_IDLE;
               len_in  = '0;
            end else if (text_byte == CHAR_QUOTE) begin
               slots[0].token_end = 1'b1;
               n       = 2'd1;
               mode_in = MODE_IDLE;
               len_in  = '0;
            end else begin
               do_add = 1'b1;
            end
         end
         MODE_WORD: begin
            do_word = 1'b1;
         end
         default: begin
            mode_in = MODE_IDLE;
            len_in  = '0;
            if (text_byte == CHAR_NUL) begin
               slots[0].text_end = 1'b1;
               n = 2'd1;
            end else if (text_byte <= CHAR_SPACE) begin
               mode_in = MODE_IDLE;
            end else if (text_byte == CHAR_SLASH) begin
               mode_in = MODE_SLASH;
            end else if (text_byte == CHAR_QUOTE) begin
               mode_in = MODE_QUOTE;
            end else begin
               mode_in = MODE_WORD;
               do_add  = 1'b1;
            end
         end
      endcase

      // byte following word content
      if (do_word) begin
         if (text_byte == CHAR_NUL) begin
            slots[n].token_end = 1'b1;
            slots[n].text_end  = 1'b1;
            n       = n + 2'd1;
            mode_in = MODE_IDLE;
            len_in  = '0;
         end else if (text_byte <= CHAR_SPACE) begin
            slots[n].token_end = 1'b1;
            n       = n + 2'd1;
            mode_in = MODE_IDLE;
            len_in  = '0;
         end else if (text_byte == CHAR_COMMA) begin
            // comma closes the word and starts the next one
            slots[n].token_end = 1'b1;
            n       = n + 2'd1;
            len_in  = '0;
            mode_in = MODE_WORD;
            do_add  = 1'b1;
         end else begin
            mode_in = MODE_WORD;
            do_add  = 1'b1;
         end
      end

      // append a token byte unless the token is full
      if (do_add && (len_in < len_limit)) begin
         len_in                = len_in + LEN_W'(1);
         slots[n].token_byte   = text_byte;
         slots[n].byte_valid   = 1'b1;
         n                     = n + 2'd1;
      end

      if (n != 2'd0) begin
         slots[n - 2'd1].last_of_run = 1'b1;
      end

      bundle.slot  = slots;
      bundle.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         len_ff  <= '0;
      end else if (advance) begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cmt_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// cmt_rsp_queue: result register bank
// Holds one bundle of up to three results and sends them one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module cmt_rsp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmt_pkg::bundle_type bundle,
   input  wire logic                load,
   output logic                     can_load,
   cmt_stream_if.source             rsp
);
   import cmt_pkg::*;

   rsp_type [RESULTS_MAX-1:0] slot_ff;
   logic [1:0]                rem_ff;
   logic                      fire;

   assign rsp.valid   = (rem_ff != 2'd0);
   assign rsp.payload = slot_ff[0];
   assign fire        = rsp.valid && rsp.ready;
   assign can_load    = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
      end else if (load) begin
         rem_ff <= bundle.count;
      end else if (fire) begin
         rem_ff <= rem_ff - 2'd1;
      end
   end

   // payload slots, shifted toward slot 0 as beats leave
   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= bundle.slot;
      end else if (fire) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
         slot_ff[2] <= '0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/comma_token_lexer.sv =====
// ----------------------------------------------------------------------------
// comma_token_lexer: streaming lexer for comma and space separated text
// Top level: input register, lexer core and result register bank.
// ----------------------------------------------------------------------------
// Usage:
//   req: one text byte per beat; byte zero ends the text and the lexer is
//        ready for a new text right after it.
//   rsp: token bytes, token end markers and the end-of-text marker, one
//        result per beat; last_of_run flags the final result of an input byte.
// Path: a byte sits in the input register, is lexed there and its results
//   load the result bank when the bank can take them; rsp valid comes from
//   the result bank register.
// Throughput: one byte per cycle while each byte gives at most one result
//   and rsp is ready. A byte that gives several results holds the result
//   bank until all its results have left, so the output port sets the rate.
//   Bytes that give no result (spaces, comments) never wait on rsp.
// Reset: synchronous; lexer to between tokens, token length to zero, held
//   input byte and pending results dropped.
// Stall: with rsp_chan.ready low the result bank holds; result-free bytes
//   still pass, the first byte with results waits in the input register and
//   req_chan.ready stays low until the bank can load again.
// ----------------------------------------------------------------------------
`default_nettype none

module comma_token_lexer #(
   parameter int MAX_TOKEN_BYTES = 1024
) (
   input  wire logic    clock,
   input  wire logic    reset,
   cmt_stream_if.sink   req_chan,
   cmt_stream_if.source rsp_chan
);
   import cmt_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   bundle_type bundle;
   logic       can_load;
   logic       advance;
   logic       load;

   // Input byte leaves the register once its results fit in the bank.
   assign advance        = in_valid_ff && ((bundle.count == 2'd0) || can_load);
   assign load           = advance && (bundle.count != 2'd0);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.payload.text_byte;
      end
   end

   cmt_lex_core #(
      .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .text_byte (in_byte_ff),
      .advance   (advance),
      .bundle    (bundle)
   );

   cmt_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .bundle   (bundle),
      .load     (load),
      .can_load (can_load),
      .rsp      (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== test/comma_token_lexer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comma_token_lexer_test: self-checking bench for the comma token lexer
// Feeds text bytes through the req channel in random bursts and checks every
// rsp beat against an in-bench lexer that tracks mode and token length.
// ----------------------------------------------------------------------------

module comma_token_lexer_test;

   import cmt_pkg::*;

   localparam int TOKEN_CAP    = 1024;  // MAX_TOKEN_BYTES of the instance
   localparam int RANDOM_ITEMS = 150;   // token-carrying bytes in the random part
   localparam int DRAIN_CYCLES = 32;
   localparam int HOLD_AT_RSP  = 50;    // rsp beat count that triggers the long hold
   localparam int HOLD_CYCLES  = 200;
   localparam int REPORT_MAX   = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cmt_stream_if #(.payload_type(req_type)) req_chan ();
   cmt_stream_if #(.payload_type(rsp_type)) rsp_chan ();

   comma_token_lexer #(
      .MAX_TOKEN_BYTES(TOKEN_CAP)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Lexer prediction: mirrors the mode machine byte by byte. Each accepted
   // req beat turns into zero to three expected rsp beats.
   // -------------------------------------------------------------------------
   mode_type    lex_mode;
   int unsigned tok_len;
   rsp_type     run_q[$];       // results of the byte being lexed
   rsp_type     expected_q[$];  // results still owed by the block

   function automatic void emit(logic [7:0] b, logic v, logic te, logic xe);
      rsp_type r;
      r.token_byte  = v ? b : 8'h00;
      r.byte_valid  = v;
      r.token_end   = te;
      r.text_end    = xe;
      r.last_of_run = 1'b0;
      run_q.push_back(r);
   endfunction

   // Token bytes past the cap are dropped silently.
   function automatic void append_token_byte(logic [7:0] b);
      if (tok_len < TOKEN_CAP - 1) begin
         tok_len++;
         emit(b, 1'b1, 1'b0, 1'b0);
      end
   endfunction

   // A byte following at least one word byte.
   function automatic void continue_word(logic [7:0] c);
      if (c == CHAR_NUL) begin
         emit(8'h00, 1'b0, 1'b1, 1'b1);
         lex_mode = MODE_IDLE;
         tok_len  = 0;
      end else if (c <= CHAR_SPACE) begin
         emit(8'h00, 1'b0, 1'b1, 1'b0);
         lex_mode = MODE_IDLE;
         tok_len  = 0;
      end else if (c == CHAR_COMMA) begin
         // comma closes this word and opens the next one with itself
         emit(8'h00, 1'b0, 1'b1, 1'b0);
         tok_len  = 0;
         lex_mode = MODE_WORD;
         append_token_byte(c);
      end else begin
         lex_mode = MODE_WORD;
         append_token_byte(c);
      end
   endfunction

   function automatic void lex_byte(logic [7:0] c);
      rsp_type r;
      run_q.delete();
      case (lex_mode)
         MODE_SLASH: begin
            if (c == CHAR_SLASH) begin
               lex_mode = MODE_LINE;
            end else if (c == CHAR_STAR) begin
               lex_mode = MODE_BLOCK;
            end else begin
               // held slash was the start of a word after all
               tok_len = 0;
               append_token_byte(CHAR_SLASH);
               continue_word(c);
            end
         end
         MODE_LINE: begin
            if (c == CHAR_NUL) begin
               emit(8'h00, 1'b0, 1'b0, 1'b1);
               lex_mode = MODE_IDLE;
            end else if (c == CHAR_LF) begin
               lex_mode = MODE_IDLE;
            end
         end
         MODE_BLOCK, MODE_STAR: begin
            if (c == CHAR_NUL) begin
               emit(8'h00, 1'b0, 1'b0, 1'b1);
               lex_mode = MODE_IDLE;
            end else if (c == CHAR_STAR) begin
               lex_mode = MODE_STAR;
            end else if (lex_mode == MODE_STAR && c == CHAR_SLASH) begin
               lex_mode = MODE_IDLE;
            end else begin
               lex_mode = MODE_BLOCK;
            end
         end
         MODE_QUOTE: begin
            if (c == CHAR_NUL) begin
               emit(8'h00, 1'b0, 1'b1, 1'b1);
               lex_mode = MODE_IDLE;
               tok_len  = 0;
            end else if (c == CHAR_QUOTE) begin
               emit(8'h00, 1'b0, 1'b1, 1'b0);
               lex_mode = MODE_IDLE;
               tok_len  = 0;
            end else begin
               append_token_byte(c);
            end
         end
         MODE_WORD: begin
            continue_word(c);
         end
         default: begin
            lex_mode = MODE_IDLE;
            tok_len  = 0;
            if (c == CHAR_NUL) begin
               emit(8'h00, 1'b0, 1'b0, 1'b1);
            end else if (c <= CHAR_SPACE) begin
               // whitespace between tokens
            end else if (c == CHAR_SLASH) begin
               lex_mode = MODE_SLASH;
            end else if (c == CHAR_QUOTE) begin
               lex_mode = MODE_QUOTE;
            end else begin
               lex_mode = MODE_WORD;
               append_token_byte(c);
            end
         end
      endcase
      foreach (run_q[i]) begin
         r = run_q[i];
         r.last_of_run = (i == run_q.size() - 1);
         expected_q.push_back(r);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Text source: the initial block fills text_q, the driver drains it.
   // -------------------------------------------------------------------------
   logic [7:0] text_q[$];
   int         token_items;

   task automatic push_byte(input logic [7:0] b);
      text_q.push_back(b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         text_q.push_back(s[i]);
      end
   endtask

   // Any byte that keeps a word going (no whitespace, no comma).
   function automatic logic [7:0] pick_word_byte();
      logic [7:0] b;
      b = 8'($urandom_range(33, 255));
      if (b == CHAR_COMMA) begin
         b = 8'h5F;
      end
      return b;
   endfunction

   // A byte that opens a word from between tokens.
   function automatic logic [7:0] pick_word_start();
      logic [7:0] b;
      b = pick_word_byte();
      if (b == CHAR_SLASH || b == CHAR_QUOTE) begin
         b = 8'h77;
      end
      return b;
   endfunction

   // Word terminator: mostly whitespace, sometimes end of text.
   function automatic logic [7:0] pick_separator();
      if ($urandom_range(0, 5) == 0) begin
         return CHAR_NUL;
      end
      return 8'($urandom_range(1, 32));
   endfunction

   // -------------------------------------------------------------------------
   // Driver: bursts of random length with random gaps. Prediction happens
   // here, on the edge where the req beat is taken.
   // -------------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left     <= 0;
         gap_left       <= 0;
         lex_mode       = MODE_IDLE;
         tok_len        = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            lex_byte(req_chan.payload.text_byte);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0 || text_q.size() == 0) begin
               req_chan.valid <= 1'b0;
               if (gap_left > 0) begin
                  gap_left <= gap_left - 1;
               end
            end else begin
               req_chan.valid             <= 1'b1;
               req_chan.payload.text_byte <= text_q.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  // a third of the bursts run back to back
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Long hold-off: once, after some traffic, rsp stays blocked long enough
   // for the block to back up and drop req ready.
   // -------------------------------------------------------------------------
   int hold_left;
   bit hold_done;
   int rsp_seen;

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && rsp_seen >= HOLD_AT_RSP) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: checks each rsp beat against the oldest expectation, and
   // drives rsp ready from a 16-bit mask, redrawn when its phase wraps, and the hold.
   // -------------------------------------------------------------------------
   logic [15:0] stall_mask;
   logic [3:0]  mask_phase;
   int          fail_count;
   rsp_type     got;
   rsp_type     want;

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_mask     <= 16'hFFFF;
         mask_phase     <= 4'd0;
         rsp_seen       <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            rsp_seen <= rsp_seen + 1;
            if (expected_q.size() == 0) begin
               note_failure($sformatf(
                  "unexpected rsp beat: byte %02h valid %0b tend %0b xend %0b last %0b",
                  got.token_byte, got.byte_valid, got.token_end, got.text_end,
                  got.last_of_run));
            end else begin
               want = expected_q.pop_front();
               if (got.token_byte !== want.token_byte || got.byte_valid !== want.byte_valid
                   || got.token_end !== want.token_end || got.text_end !== want.text_end
                   || got.last_of_run !== want.last_of_run) begin
                  note_failure($sformatf({"rsp mismatch: exp byte %02h valid %0b tend %0b ",
                     "xend %0b last %0b, got byte %02h valid %0b tend %0b xend %0b last %0b"},
                     want.token_byte, want.byte_valid, want.token_end, want.text_end,
                     want.last_of_run, got.token_byte, got.byte_valid, got.token_end,
                     got.text_end, got.last_of_run));
               end
            end
         end
         mask_phase <= mask_phase + 4'd1;
         if (mask_phase == 4'd15) begin
            // a third of the windows never stall
            stall_mask <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom());
         end
         rsp_chan.ready <= stall_mask[mask_phase] && (hold_left == 0);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      int         kind;
      int         len;
      logic [7:0] b;

      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      fail_count       = 0;
      token_items      = 0;

      // Directed text: every mode, the end of text in each but the star run, slash cases.
      push_byte(CHAR_NUL);                  // end of text between tokens
      push_text("ab,c"); push_byte(CHAR_NUL); // comma split, end inside a word
      push_text("/, ");                     // slash then comma: three results
      push_text("//x\n");                   // line comment
      push_text("/*a**/");                  // block comment, star run before close
      push_text("\"q ,"); push_byte(8'hFF); push_text("\"");
      push_byte(8'h80); push_byte(8'h7F); push_byte(8'h01);
      push_text("\"u"); push_byte(CHAR_NUL);  // unclosed quote
      push_text("/*"); push_byte(CHAR_NUL);   // unclosed block comment
      push_text("//"); push_byte(CHAR_NUL);   // end inside a line comment
      push_text("/"); push_byte(CHAR_NUL);    // lone slash at end of text

      // Random text: mostly well-formed tokens with random content.
      while (token_items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2, 3: begin
               len = $urandom_range(1, 8);
               push_byte(pick_word_start());
               for (int i = 1; i < len; i++) begin
                  push_byte(($urandom_range(0, 5) == 0) ? CHAR_COMMA : pick_word_byte());
               end
               push_byte(pick_separator());
               token_items += len + 1;
            end
            4, 5: begin
               len = $urandom_range(0, 8);
               push_byte(CHAR_QUOTE);
               for (int i = 0; i < len; i++) begin
                  b = 8'($urandom_range(1, 255));
                  push_byte((b == CHAR_QUOTE) ? CHAR_COMMA : b);
               end
               push_byte(($urandom_range(0, 7) == 0) ? CHAR_NUL : CHAR_QUOTE);
               token_items += len + 2;
            end
            6: begin
               push_text("//");
               len = $urandom_range(0, 5);
               for (int i = 0; i < len; i++) begin
                  b = 8'($urandom_range(1, 255));
                  push_byte((b == CHAR_LF) ? CHAR_STAR : b);
               end
               push_byte(($urandom_range(0, 5) == 0) ? CHAR_NUL : CHAR_LF);
            end
            7: begin
               push_text("/*");
               len = $urandom_range(0, 6);
               for (int i = 0; i < len; i++) begin
                  case ($urandom_range(0, 3))
                     0:       push_byte(CHAR_STAR);
                     1:       push_byte(CHAR_SLASH);
                     default: push_byte(8'($urandom_range(1, 255)));
                  endcase
               end
               if ($urandom_range(0, 5) == 0) begin
                  push_byte(CHAR_NUL);
               end else begin
                  push_text("*/");
               end
            end
            8: begin
               // slash that turns out to start a word
               len = $urandom_range(0, 5);
               push_byte(CHAR_SLASH);
               for (int i = 0; i < len; i++) begin
                  b = ($urandom_range(0, 4) == 0) ? CHAR_COMMA : pick_word_byte();
                  push_byte((i == 0 && (b == CHAR_SLASH || b == CHAR_STAR)) ? 8'h78 : b);
               end
               push_byte(pick_separator());
               token_items += len + 2;
            end
            default: begin
               len = $urandom_range(1, 4);
               for (int i = 0; i < len; i++) begin
                  push_byte(8'($urandom_range(0, 255)));
               end
               token_items += len;
            end
         endcase
      end
      push_byte(CHAR_NUL);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Drain: all bytes taken and every expected result seen.
      @(negedge clock);
      while (text_q.size() != 0 || req_chan.valid || expected_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (expected_q.size() != 0) begin
         note_failure($sformatf("%0d rsp beats never arrived", expected_q.size()));
      end
      if (fail_count == 0) begin
         $display("comma_token_lexer_test OK");
      end else begin
         $display("comma_token_lexer_test NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("comma_token_lexer_test NOT OK");
      $finish;
   end

endmodule
